[rtl/bitmap_set_clear_find_first_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap allocator
// Clocked on clk, disabled while rst_n is low. Define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef BITMAP_SET_CLEAR_FIND_FIRST_MACROS_SVH
`define BITMAP_SET_CLEAR_FIND_FIRST_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BSCFF_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define BSCFF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BSCFF_ASSERT(lbl, pre, post, msg)
`define BSCFF_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[rtl/bscff_pkg.sv]
// ---------------------------------------------------------------------------
// bscff_pkg
// Shared constants and operation codes for the bitmap allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bscff_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int WORD_BITS_DEF = 64;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 8;
    localparam int SIZE_W  = 9;
    localparam int COUNT_W = 9;
    // bit positions inside a scan, one bit above the size range
    localparam int POS_W   = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FIND  = 2'd3;

endpackage

[rtl/bitmap_set_clear_find_first.sv]
// Test/set/clear: accepted word passes ST_BIT_RD, ST_BIT_OP and ST_DONE; next word taken back in ST_IDLE.
// Find: one bitmap word per cycle through the single RAM read port, read one word
//   ahead and examined from the registered read data; the result then waits in
//   ST_DONE for the output register; an early hit ends the scan sooner; empty size:
//   straight to ST_DONE with no scan; next word taken back in ST_IDLE.
// Reset (rst_n, async, low): a clearing pass zeroes the CAPACITY/WORD_BITS (rounded up)
//   RAM words, one word a cycle, with in_ready low; count zero, size 256.
// ---------------------------------------------------------------------------
// bitmap_set_clear_find_first
// Bitmap allocator with set-bit count and lowest set/clear bit search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitmap_set_clear_find_first_macros.svh"

module bitmap_set_clear_find_first
    import bscff_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    // size_in_use write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SIZE_W-1:0]  cfg_data,

    // operation word
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [IDX_W-1:0]   bit_pos,
    input  logic               find_ones,

    // result word
    output logic               out_valid,
    input  logic               out_ready,
    output logic               bit_value,
    output logic               found,
    output logic [IDX_W-1:0]   found_index,
    output logic [COUNT_W-1:0] set_count,
    output logic               index_error
);

    localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    // size clip, kept inside the 9-bit size range
    localparam int CAP_LIM   = (CAPACITY > 511) ? 511 : CAPACITY;

    // idx / WORD_BITS by reciprocal: exact since 255 * (WORD_BITS-1) < 2^16
    localparam int DIV_SHIFT = 16;
    localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int DIV_W     = IDX_W + DIV_SHIFT + 1;

    // one-hot sequencer
    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_BIT_RD = 6'b000100,
        ST_BIT_OP = 6'b001000,
        ST_SCAN   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    // latched operation
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic                 want_reg, want_next;
    logic                 err_reg, err_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     q_reg, q_next;
    logic [BW-1:0]        bit_reg, bit_next;

    // scan bookkeeping: base_reg is the first position of the word in rd_data_reg
    logic [POS_W-1:0]     base_reg, base_next;
    logic [AW-1:0]        issue_reg, issue_next;
    logic                 dvld_reg, dvld_next;

    // staged result
    logic                 res_bit_reg, res_bit_next;
    logic                 res_found_reg, res_found_next;
    logic [IDX_W-1:0]     res_idx_reg, res_idx_next;
    logic                 res_err_reg, res_err_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 bit_value_reg, bit_value_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     found_index_reg, found_index_next;
    logic [COUNT_W-1:0]   set_count_reg, set_count_next;
    logic                 index_error_reg, index_error_next;

    // bitmap RAM
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [SIZE_W-1:0]    eff;
    logic [DIV_W-1:0]     div_prod;
    logic [IDX_W-1:0]     div_quot;
    logic [WORD_BITS-1:0] bit_onehot;
    logic                 cur_bit;

    logic [POS_W-1:0]     rem_pos;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] hits;
    logic [WORD_BITS-1:0] low_hit;
    logic [BW-1:0]        hit_pos;
    logic                 scan_hit;
    logic                 scan_last;
    logic [POS_W-1:0]     found_pos;

    // effective size = min(size_in_use, CAPACITY)
    assign eff = (size_reg > SIZE_W'(CAP_LIM)) ? SIZE_W'(CAP_LIM) : size_reg;

    // word number of the incoming index
    assign div_prod = DIV_W'(bit_pos) * DIV_W'(DIV_MUL);
    assign div_quot = div_prod[DIV_SHIFT +: IDX_W];

    assign bit_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_reg;
    assign cur_bit    = rd_data_reg[bit_reg];

    // scan of the word in rd_data_reg: mask off positions at or past the size,
    // isolate the lowest hit and encode it
    assign rem_pos = POS_W'(eff) - base_reg;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            scan_mask[b] = (POS_W'(b) < rem_pos);
        end
    end

    assign hits     = (want_reg ? rd_data_reg : ~rd_data_reg) & scan_mask;
    assign low_hit  = hits & (~hits + {{(WORD_BITS-1){1'b0}}, 1'b1});
    assign scan_hit = |hits;

    always_comb
    begin
        hit_pos = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (low_hit[b])
            begin
                hit_pos = hit_pos | BW'(b);
            end
        end
    end

    assign scan_last = (base_reg + POS_W'(WORD_BITS)) >= POS_W'(eff);
    assign found_pos = base_reg + POS_W'(hit_pos);

    // the user writes config only while idle; the block does not enforce this and always takes it
    assign cfg_ready = 1'b1;
    assign size_next = (cfg_valid && cfg_ready) ? cfg_data : size_reg;

    assign in_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        want_next      = want_reg;
        err_next       = err_reg;
        idx_next       = idx_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        base_next      = base_reg;
        issue_next     = issue_reg;
        dvld_next      = dvld_reg;
        res_bit_next   = res_bit_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        res_err_next   = res_err_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg;
        wr_en          = 1'b0;
        wr_addr        = clr_addr_reg;
        wr_data        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_addr_reg == AW'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    want_next = find_ones;
                    idx_next  = bit_pos;
                    q_next    = div_quot;
                    err_next  = (SIZE_W'(bit_pos) >= eff);
                    if (kind == KIND_FIND)
                    begin
                        issue_next = '0;
                        dvld_next  = 1'b0;
                        base_next  = '0;
                        if (eff == '0)
                        begin
                            // nothing to search
                            res_bit_next   = 1'b0;
                            res_found_next = 1'b0;
                            res_idx_next   = '0;
                            res_err_next   = 1'b0;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = ST_BIT_RD;
                    end
                end
            end

            ST_BIT_RD:
            begin
                rd_en      = !err_reg;
                rd_addr    = AW'(q_reg);
                bit_next   = BW'(idx_reg - IDX_W'(q_reg * WORD_BITS));
                state_next = ST_BIT_OP;
            end

            ST_BIT_OP:
            begin
                res_bit_next   = !err_reg && cur_bit;
                res_found_next = 1'b0;
                res_idx_next   = '0;
                res_err_next   = err_reg;
                wr_addr        = AW'(q_reg);
                if (!err_reg)
                begin
                    if (kind_reg == KIND_SET && !cur_bit)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = rd_data_reg | bit_onehot;
                        count_next = count_reg + 1'b1;
                    end
                    else if (kind_reg == KIND_CLEAR && cur_bit)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = rd_data_reg & ~bit_onehot;
                        count_next = count_reg - 1'b1;
                    end
                end
                state_next = ST_DONE;
            end

            ST_SCAN:
            begin
                // read one word ahead while the previous one is examined
                rd_en     = 1'b1;
                rd_addr   = issue_reg;
                dvld_next = 1'b1;
                if (issue_reg != AW'(NUM_WORDS - 1))
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (dvld_reg)
                begin
                    base_next = base_reg + POS_W'(WORD_BITS);
                    if (scan_hit || scan_last)
                    begin
                        res_bit_next   = 1'b0;
                        res_found_next = scan_hit;
                        res_idx_next   = scan_hit ? found_pos[IDX_W-1:0] : '0;
                        res_err_next   = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: loads when the staged result leaves ST_DONE
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        bit_value_next   = bit_value_reg;
        found_next       = found_reg;
        found_index_next = found_index_reg;
        set_count_next   = set_count_reg;
        index_error_next = index_error_reg;
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        begin
            out_valid_next   = 1'b1;
            bit_value_next   = res_bit_reg;
            found_next       = res_found_reg;
            found_index_next = res_idx_reg;
            set_count_next   = count_reg;
            index_error_next = res_err_reg;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            size_reg      <= SIZE_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            dvld_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            size_reg      <= size_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            dvld_reg      <= dvld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        want_reg        <= want_next;
        err_reg         <= err_next;
        idx_reg         <= idx_next;
        q_reg           <= q_next;
        bit_reg         <= bit_next;
        base_reg        <= base_next;
        issue_reg       <= issue_next;
        res_bit_reg     <= res_bit_next;
        res_found_reg   <= res_found_next;
        res_idx_reg     <= res_idx_next;
        res_err_reg     <= res_err_next;
        bit_value_reg   <= bit_value_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
        set_count_reg   <= set_count_next;
        index_error_reg <= index_error_next;
    end

    // bitmap RAM, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign bit_value   = bit_value_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign set_count   = set_count_reg;
    assign index_error = index_error_reg;

    // an out-of-range index never touches the map
    `BSCFF_ASSERT(a_err_no_write, state_reg == ST_BIT_OP && err_reg, !wr_en, "write on bad index")
    // a find result never carries bit-op flags
    `BSCFF_ASSERT(a_find_clean, out_valid && found, !index_error && !bit_value, "find flags mixed")
    // every bit-op write moves the count
    `BSCFF_ASSERT_NEXT(a_write_count, state_reg == ST_BIT_OP && wr_en, count_reg != $past(count_reg), "count stuck on write")

endmodule

[verif/bitmap_result_checker.sv]
// ---------------------------------------------------------------------------
// bitmap_result_checker
// Watches the size, operation and result channels of the bitmap block and
// keeps its own copy of the map, the set-bit count and the size in use.
// Every accepted operation word is predicted on the spot. Every accepted
// result word is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_result_checker
    import bscff_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [SIZE_W-1:0]  cfg_data,

    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [IDX_W-1:0]   bit_pos,
    input  logic               find_ones,

    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               bit_value,
    input  logic               found,
    input  logic [IDX_W-1:0]   found_index,
    input  logic [COUNT_W-1:0] set_count,
    input  logic               index_error,

    output int                 mismatches,
    output int                 pending
);

    typedef struct packed {
        logic               bit_value;
        logic               found;
        logic [IDX_W-1:0]   found_index;
        logic [COUNT_W-1:0] set_count;
        logic               index_error;
    } op_result_t;

    logic [CAPACITY_DEF-1:0] map_bits;
    logic [COUNT_W-1:0]      ones_total;
    logic [SIZE_W-1:0]       size_reg;
    op_result_t              awaited_results[$];

    // applies one operation to the shadow map and returns its result word
    function automatic op_result_t run_bitmap_op(
        input logic [KIND_W-1:0] op,
        input logic [IDX_W-1:0]  idx,
        input logic              want_one
    );
        op_result_t r;
        int         limit;
        bit         hit;
        r     = '0;
        hit   = 1'b0;
        limit = (size_reg > CAPACITY_DEF) ? CAPACITY_DEF : int'(size_reg);
        if (op == KIND_FIND)
        begin
            for (int i = 0; i < limit; i++)
            begin
                if (!hit && map_bits[i] == want_one)
                begin
                    hit           = 1'b1;
                    r.found       = 1'b1;
                    r.found_index = IDX_W'(i);
                end
            end
        end
        else if (int'(idx) >= limit)
        begin
            r.index_error = 1'b1;
        end
        else
        begin
            r.bit_value = map_bits[idx];
            if (op == KIND_SET && !r.bit_value)
            begin
                map_bits[idx] = 1'b1;
                ones_total    = ones_total + 1'b1;
            end
            else if (op == KIND_CLEAR && r.bit_value)
            begin
                map_bits[idx] = 1'b0;
                ones_total    = ones_total - 1'b1;
            end
        end
        r.set_count = ones_total;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        op_result_t want;
        if (!rst_n)
        begin
            map_bits   = '0;
            ones_total = '0;
            size_reg   = SIZE_RESET;
            mismatches = 0;
            awaited_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected none, actual %0d",
                             $time, set_count);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("bit_value", want.bit_value, bit_value);
                    compare_field("found", want.found, found);
                    compare_field("found_index", want.found_index, found_index);
                    compare_field("set_count", want.set_count, set_count);
                    compare_field("index_error", want.index_error, index_error);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                size_reg = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                awaited_results.push_back(run_bitmap_op(kind, bit_pos, find_ones));
            end
        end
        pending = awaited_results.size();
    end

endmodule

[verif/tb_bitmap_set_clear_find_first.sv]
// ---------------------------------------------------------------------------
// tb_bitmap_set_clear_find_first
// Drives operation words and size writes into the bitmap block, with random
// bursts of idle cycles on the sender and stalls on the receiver. A checker
// beside the block predicts and compares every result word; this module
// only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_set_clear_find_first;
    import bscff_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES  = 10;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;

    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_data    = '0;

    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [KIND_W-1:0]  kind        = KIND_TEST;
    logic [IDX_W-1:0]   bit_pos     = '0;
    logic               find_ones   = 1'b0;

    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               bit_value;
    logic               found;
    logic [IDX_W-1:0]   found_index;
    logic [COUNT_W-1:0] set_count;
    logic               index_error;

    int                 mismatches;
    int                 pending;

    int                 cycle_count = 0;
    int                 stall_left  = 0;
    int                 live_size   = CAPACITY_DEF;  // effective size the block is using
    bit                 calm        = 1'b0;          // no idling on either side when set

    always #4 clk = ~clk;

    bitmap_set_clear_find_first u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .bit_pos     (bit_pos),
        .find_ones   (find_ones),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bit_value   (bit_value),
        .found       (found),
        .found_index (found_index),
        .set_count   (set_count),
        .index_error (index_error)
    );

    bitmap_result_checker u_result_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .bit_pos     (bit_pos),
        .find_ones   (find_ones),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bit_value   (bit_value),
        .found       (found),
        .found_index (found_index),
        .set_count   (set_count),
        .index_error (index_error),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Hard stop: a hung handshake ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure: ready drops in random bursts.
    // Changes on the falling edge so the block sees it settled at the rising one.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Present one operation word and hold it until the block takes it.
    // Valid stays high across back-to-back words: the next call drives it
    // again at a later falling edge, never twice in one step.
    task automatic send_op(input logic [KIND_W-1:0] op, input int idx, input logic ones);
        @(negedge clk);
        in_valid  <= 1'b1;
        kind      <= op;
        bit_pos   <= IDX_W'(idx);
        find_ones <= ones;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sender idle burst, now and then.
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    // Stop sending and wait until every predicted result word has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Size writes only go in with the block idle.
    task automatic write_size(input int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= SIZE_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        live_size = (value > CAPACITY_DEF) ? CAPACITY_DEF : value;
    endtask

    // One random word. set_pct/clear_pct steer the map toward full or empty;
    // test takes a tenth and find the rest. Most indices land inside the
    // size in use, a tenth anywhere in the field's range.
    task automatic random_op(input int set_pct, input int clear_pct);
        int                roll;
        int                idx;
        logic [KIND_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < set_pct)
            op = KIND_SET;
        else if (roll < set_pct + clear_pct)
            op = KIND_CLEAR;
        else if (roll < set_pct + clear_pct + 10)
            op = KIND_TEST;
        else
            op = KIND_FIND;
        if (live_size == 0 || $urandom_range(0, 9) == 0)
            idx = $urandom_range(0, 255);
        else
            idx = $urandom_range(0, live_size - 1);
        sender_gap();
        send_op(op, idx, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : stimulus
        int phase_size[NUM_PHASES];
        int words;
        int set_pct;
        int clear_pct;

        // 8 fills up so a search for clear bits comes back empty; 0 is the empty size and 511 lies
        // past capacity; 64/65 sit on a word boundary
        phase_size = '{8, 256, 1, 100, 511, 64, 0, 65, 200, 256};

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part, full size after reset ----
        send_op(KIND_FIND, 0, 1'b1);       // empty map: no set bit
        send_op(KIND_FIND, 0, 1'b0);       // lowest clear bit is 0
        send_op(KIND_TEST, 0, 1'b0);
        send_op(KIND_SET, 0, 1'b0);
        send_op(KIND_SET, 0, 1'b0);        // already set, count holds
        send_op(KIND_SET, 255, 1'b0);      // top bit
        send_op(KIND_SET, 63, 1'b0);       // last bit of the first word
        send_op(KIND_SET, 64, 1'b0);       // first bit of the second word
        send_op(KIND_FIND, 0, 1'b1);
        send_op(KIND_CLEAR, 0, 1'b0);
        send_op(KIND_CLEAR, 0, 1'b0);      // already clear, count holds
        send_op(KIND_FIND, 0, 1'b1);       // now lands on 63
        send_op(KIND_TEST, 255, 1'b0);

        // lowered size: bit 255 stays counted but is out of reach
        write_size(100);
        send_op(KIND_SET, 100, 1'b0);      // just past the size
        send_op(KIND_TEST, 255, 1'b0);
        send_op(KIND_CLEAR, 99, 1'b0);
        send_op(KIND_FIND, 0, 1'b0);

        // empty size: every index errors, every search misses
        write_size(0);
        send_op(KIND_TEST, 0, 1'b0);
        send_op(KIND_FIND, 0, 1'b1);
        send_op(KIND_FIND, 0, 1'b0);

        // oversize register value is clamped to capacity
        write_size(511);
        send_op(KIND_TEST, 255, 1'b0);
        send_op(KIND_CLEAR, 255, 1'b0);

        // single bit in use
        write_size(1);
        send_op(KIND_SET, 0, 1'b0);
        send_op(KIND_FIND, 0, 1'b0);       // nothing clear below size 1
        send_op(KIND_FIND, 0, 1'b1);

        // ---- random part, one size per phase ----
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
            begin
                // last stretch runs with no idling at all, random size
                phase_size[p] = $urandom_range(1, CAPACITY_DEF);
                calm          = 1'b1;
            end
            write_size(phase_size[p]);
            case (p % 3)
                0:
                begin
                    set_pct   = 60;
                    clear_pct = 10;
                end
                1:
                begin
                    set_pct   = 20;
                    clear_pct = 50;
                end
                default:
                begin
                    set_pct   = 35;
                    clear_pct = 35;
                end
            endcase
            if (phase_size[p] == 0)
                words = 10;
            else if (p == NUM_PHASES - 1)
                words = 80;
            else
                words = 50;
            repeat (words)
                random_op(set_pct, clear_pct);
        end

        // wind down: everything back, then let the pipe settle
        drain_results();
        repeat (20)
            @(negedge clk);

        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bscff_pkg.sv
rtl/bitmap_set_clear_find_first.sv
verif/bitmap_result_checker.sv
verif/tb_bitmap_set_clear_find_first.sv
